[hw/rtl/tpip_pkg.sv]
`timescale 1ns / 1ps

package tpip_pkg;

  localparam int unsigned MAX_PARTS = 8;
  localparam int unsigned WORD_BITS = 24;
  localparam int unsigned PART_W    = 3;   // partition index width
  localparam int unsigned BITS_W    = 2;   // bits-per-index count (1..3)
  localparam int unsigned FILL_W    = 5;   // accumulator fill count
  localparam int unsigned THR_W     = 33;  // UQ1.32
  localparam int unsigned PCNT_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes; thresholds 1..7 sit at their own index.
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 3'd0;

  localparam logic [PCNT_W-1:0] PART_COUNT_RST = 4'd2;

  typedef enum logic {
    FUNC_PACK  = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

  typedef logic [MAX_PARTS-1:1][THR_W-1:0] thr_arr_t;

  // Classifier to packer.
  typedef struct packed {
    logic              flush;
    logic [PART_W-1:0] sel;
    logic [BITS_W-1:0] bits;
  } pack_req_t;

  // Packer result for the current request.
  typedef struct packed {
    logic                 word_valid;
    logic [WORD_BITS-1:0] word;
  } pack_res_t;

endpackage

[hw/rtl/tpip_classify.sv]
`timescale 1ns / 1ps

// Parallel comparator bank: highest partition below the count whose
// threshold is at or below the weight.
module tpip_classify (
  input  logic                                    func_i,
  input  logic [tpip_pkg::THR_W-1:0]              weight_i,
  input  logic [tpip_pkg::PCNT_W-1:0]             part_count_i,
  input  tpip_pkg::thr_arr_t                      thr_i,
  output tpip_pkg::pack_req_t                     req_o
);

  logic [tpip_pkg::PCNT_W-1:0] parts;
  logic [tpip_pkg::PART_W-1:0] sel;
  logic [tpip_pkg::BITS_W-1:0] bits;

  // clamp count to 2..MAX_PARTS
  always_comb begin
    parts = part_count_i;
    if (part_count_i < 4'd2) begin
      parts = 4'd2;
    end else if (part_count_i > tpip_pkg::PCNT_W'(tpip_pkg::MAX_PARTS)) begin
      parts = tpip_pkg::PCNT_W'(tpip_pkg::MAX_PARTS);
    end
  end

  // ceil(log2(parts))
  always_comb begin
    if (parts <= 4'd2) begin
      bits = 2'd1;
    end else if (parts <= 4'd4) begin
      bits = 2'd2;
    end else begin
      bits = 2'd3;
    end
  end

  // ascending scan, so the highest qualifying index wins
  always_comb begin
    sel = '0;
    for (int j = 1; j < tpip_pkg::MAX_PARTS; j++) begin
      if ((tpip_pkg::PCNT_W'(j) < parts) && (weight_i >= thr_i[j])) begin
        sel = tpip_pkg::PART_W'(j);
      end
    end
  end

  always_comb begin
    req_o.flush = (func_i == tpip_pkg::FUNC_FLUSH);
    req_o.sel   = req_o.flush ? '0 : sel;
    req_o.bits  = bits;
  end

endmodule

[hw/rtl/tpip_packer.sv]
`timescale 1ns / 1ps

// MSB-first shift packer with fill count; emits a word when 24 bits are
// full or on flush with bits pending.
module tpip_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  tpip_pkg::pack_req_t req_i,
  output tpip_pkg::pack_res_t res_o
);

  logic [tpip_pkg::WORD_BITS-1:0] acc_q, acc_d;
  logic [tpip_pkg::FILL_W-1:0]    fill_q, fill_d;

  logic [tpip_pkg::WORD_BITS-1:0] acc_shift;
  logic [tpip_pkg::FILL_W-1:0]    fill_sum;
  logic [tpip_pkg::FILL_W-1:0]    pad_amt;
  logic [tpip_pkg::WORD_BITS-1:0] flush_word;

  always_comb begin
    acc_shift = (acc_q << req_i.bits) | tpip_pkg::WORD_BITS'(req_i.sel);
    fill_sum  = fill_q + tpip_pkg::FILL_W'(req_i.bits);
    pad_amt   = tpip_pkg::FILL_W'(tpip_pkg::WORD_BITS) - fill_q;
    flush_word = (fill_q < tpip_pkg::FILL_W'(tpip_pkg::WORD_BITS)) ?
                 (acc_q << pad_amt) : acc_q;

    acc_d            = acc_q;
    fill_d           = fill_q;
    res_o.word_valid = 1'b0;
    res_o.word       = '0;

    if (req_i.flush) begin
      if (fill_q != '0) begin
        res_o.word_valid = 1'b1;
        res_o.word       = flush_word;
        acc_d            = '0;
        fill_d           = '0;
      end
    end else if (fill_sum >= tpip_pkg::FILL_W'(tpip_pkg::WORD_BITS)) begin
      // word complete (or overrun after a width change): emit and clear
      res_o.word_valid = 1'b1;
      res_o.word       = acc_shift;
      acc_d            = '0;
      fill_d           = '0;
    end else begin
      acc_d  = acc_shift;
      fill_d = fill_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      fill_q <= '0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      fill_q <= fill_d;
    end
  end

endmodule

[hw/rtl/threshold_partition_index_packer.sv]
`timescale 1ns / 1ps

// Sorts each UQ1.32 weight into a partition (the highest index below
// part_count whose threshold is at or below the weight; partition 0 has an
// implicit zero threshold) and packs the index MSB-first into 24-bit words,
// 1, 2 or 3 bits per index depending on part_count. Every request yields one
// result: the partition plus, when 24 bits are complete, the finished word.
// A flush request left-aligns pending bits, zero-pads and emits them.
// Throughput is one request per cycle unless stalled (input register, then
// comparator bank + shift packer into the result register). The only stall
// source is the downstream tready, which reaches s_axis_tready through the
// two stage valids. Configuration writes take effect on the next cycle and
// must only be made while the block holds no request.
module threshold_partition_index_packer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [tpip_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpip_pkg::THR_W-1:0]      cfg_data_i,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [39:0]                     s_axis_tdata,   // [32:0] weight, rest 0
  input  logic                            s_axis_tuser,   // [0] func
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,   // [2:0] partition, [26:3] packed_word
  output logic                            m_axis_tuser    // [0] word_valid
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [tpip_pkg::PCNT_W-1:0] part_count_q;
  tpip_pkg::thr_arr_t          thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_count_q <= tpip_pkg::PART_COUNT_RST;
      thr_q        <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tpip_pkg::CFG_PART_COUNT) begin
        part_count_q <= cfg_data_i[tpip_pkg::PCNT_W-1:0];
      end
      for (int j = 1; j < tpip_pkg::MAX_PARTS; j++) begin
        if (cfg_idx_i == tpip_pkg::CFG_IDX_W'(j)) begin
          thr_q[j] <= cfg_data_i;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: input stage refills while the result stage is stalled, so
  // one request can wait in each stage.
  // ---------------------------------------------------------------------
  logic in_valid_q;
  logic out_valid_q;
  logic advance;       // input stage moves into the result stage

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  logic                       in_func_q;
  logic [tpip_pkg::THR_W-1:0] in_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q   <= s_axis_tuser;
      in_weight_q <= s_axis_tdata[tpip_pkg::THR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Compute: comparator bank, then packer (state advances with the request)
  // ---------------------------------------------------------------------
  tpip_pkg::pack_req_t req;
  tpip_pkg::pack_res_t res;

  tpip_classify u_classify (
    .func_i       (in_func_q),
    .weight_i     (in_weight_q),
    .part_count_i (part_count_q),
    .thr_i        (thr_q),
    .req_o        (req)
  );

  tpip_packer u_packer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (req),
    .res_o  (res)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [tpip_pkg::PART_W-1:0]    out_part_q;
  logic                           out_wv_q;
  logic [tpip_pkg::WORD_BITS-1:0] out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_part_q <= req.sel;
      out_wv_q   <= res.word_valid;
      out_word_q <= res.word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_wv_q;
  assign m_axis_tdata  = {5'd0, out_word_q, out_part_q};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a request leaving the input stage always lands in the result stage
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("request lost between stages");

  // packed word is zero whenever no word is flagged
  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[26:3] == '0))
    else $error("packed_word nonzero without word_valid");

  // an empty input stage never back-pressures upstream
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("stall with empty input stage");

endmodule
